// File: rtl/core/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg: shared definitions for the greedy coin change block
// Widths, register indexes, controller/datapath interface types and the
// helper that clamps the configured denomination count.
// ----------------------------------------------------------------------------
package gcc_pkg;

	localparam int MAX_DENOMS   = 6;
	localparam int AMOUNT_BITS  = 32;
	localparam int DENOM_BITS   = 16;
	localparam int COUNT_BITS   = 3;
	localparam int IDX_BITS     = 3;
	localparam int REG_IDX_BITS = 3;
	localparam int NUM_REGS     = 7;
	localparam int STEP_BITS    = $clog2(AMOUNT_BITS);

	// register indexes
	localparam logic [REG_IDX_BITS-1:0] REG_DENOM_COUNT = REG_IDX_BITS'(0);
	localparam logic [REG_IDX_BITS-1:0] REG_DENOM_FIRST = REG_IDX_BITS'(1);

	typedef logic [MAX_DENOMS-1:0][DENOM_BITS-1:0] gcc_denoms_t;

	// controller -> datapath
	typedef struct packed {
		logic                load;   // capture a new amount
		logic                setup;  // prepare the divider for the current denomination
		logic                step;   // one quotient bit
		logic                emit;   // load the output register
		logic                last;   // current denomination is the final one in use
		logic [IDX_BITS-1:0] index;  // current denomination
	} gcc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic skip;      // remainder or denomination is zero: no division
		logic out_free;  // output register can take a word this cycle
	} gcc_sts_t;

	// zero acts as one, anything above the maximum acts as the maximum
	function automatic logic [COUNT_BITS-1:0] active_count(input logic [COUNT_BITS-1:0] c);
		logic [COUNT_BITS-1:0] r;
		r = c;
		if (c == '0) begin
			r = COUNT_BITS'(1);
		end else if (c > COUNT_BITS'(MAX_DENOMS)) begin
			r = COUNT_BITS'(MAX_DENOMS);
		end
		return r;
	endfunction

endpackage

// File: rtl/core/gcc_ctrl.sv
// ----------------------------------------------------------------------------
// gcc_ctrl: sequencer for the greedy coin change block
// Walks the denominations in use, runs the shared divider one bit per cycle
// and hands each result to the output register.
// ----------------------------------------------------------------------------
module gcc_ctrl
	import gcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COUNT_BITS-1:0] count,
	input  gcc_sts_t              sts,
	output gcc_cmd_t              cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]           state_q;
	logic [IDX_BITS-1:0]  idx_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 last;

	assign last = (idx_q == IDX_BITS'(count - COUNT_BITS'(1)));

	always_comb begin
		cmd       = '0;
		cmd.index = idx_q;
		cmd.last  = last;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SETUP: cmd.setup = 1'b1;
			ST_DIV:   cmd.step  = 1'b1;
			ST_EMIT:  cmd.emit  = sts.out_free;
			default:  cmd       = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SETUP;
						idx_q   <= '0;
					end
				end
				ST_SETUP: begin
					step_q  <= '0;
					state_q <= sts.skip ? ST_EMIT : ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_BITS'(1);
					if (step_q == STEP_BITS'(AMOUNT_BITS - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (last) begin
							state_q <= ST_IDLE;
							idx_q   <= '0;
						end else begin
							state_q <= ST_SETUP;
							idx_q   <= idx_q + IDX_BITS'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/gcc_dp.sv
// ----------------------------------------------------------------------------
// gcc_dp: datapath for the greedy coin change block
// Remainder register, restoring divider (one quotient bit per cycle) and
// the output register.
// ----------------------------------------------------------------------------
module gcc_dp
	import gcc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  gcc_cmd_t               cmd,
	output gcc_sts_t               sts,
	input  gcc_denoms_t            denoms,
	input  logic [AMOUNT_BITS-1:0] amount,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [IDX_BITS-1:0]    denom_index,
	output logic [AMOUNT_BITS-1:0] coin_count,
	output logic                   is_last,
	output logic                   solved,
	output logic [AMOUNT_BITS-1:0] leftover
);

	logic [AMOUNT_BITS-1:0] rem_q;      // amount still to change
	logic [AMOUNT_BITS-1:0] quo_q;      // dividend shifting out, quotient shifting in
	logic [DENOM_BITS-1:0]  part_q;     // partial remainder
	logic                   div_used_q;
	logic                   out_valid_q;

	logic [DENOM_BITS-1:0]  denom;
	logic [DENOM_BITS:0]    trial;
	logic [DENOM_BITS:0]    diff;
	logic                   fits;
	logic [AMOUNT_BITS-1:0] coins;
	logic [AMOUNT_BITS-1:0] left;

	assign denom = denoms[cmd.index];
	assign trial = {part_q, quo_q[AMOUNT_BITS-1]};
	assign diff  = trial - {1'b0, denom};
	assign fits  = (trial >= {1'b0, denom});

	assign coins = div_used_q ? quo_q : '0;
	assign left  = div_used_q ? AMOUNT_BITS'(part_q) : rem_q;

	assign sts.skip     = (rem_q == '0) || (denom == '0);
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_used_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.setup) begin
				div_used_q <= !sts.skip;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= amount;
		end else if (cmd.emit) begin
			rem_q <= left;
		end
		if (cmd.setup) begin
			quo_q  <= rem_q;
			part_q <= '0;
		end else if (cmd.step) begin
			quo_q  <= {quo_q[AMOUNT_BITS-2:0], fits};
			part_q <= fits ? diff[DENOM_BITS-1:0] : trial[DENOM_BITS-1:0];
		end
		if (cmd.emit) begin
			denom_index <= cmd.index;
			coin_count  <= coins;
			is_last     <= cmd.last;
			solved      <= cmd.last && (left == '0);
			leftover    <= left;
		end
	end

endmodule

// File: rtl/core/greedy_coin_change.sv
// ----------------------------------------------------------------------------
// greedy_coin_change: greedy (cashier's) coin change engine
// Breaks each amount into coins over up to six denominations loaded largest
// first, one result word per denomination in use.
// ----------------------------------------------------------------------------
// Each amount word yields denom_count result words, in denomination order.
// Per denomination the block passes a setup state, then the shared restoring
// divider (one quotient bit per cycle) unless the remainder or denomination
// is zero, then an emit state that loads the output register once it can
// take a word. One amount is worked at a time; a new amount is taken as soon
// as the last result word sits in the output register. Denominations are not
// sorted here; software loads them in descending order. A count of zero acts
// as one, a count above six acts as six, and a zero denomination takes no
// coins. The user must write configuration only while idle; the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module greedy_coin_change
	import gcc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// config write port
	input  logic                    wr_en,
	input  logic [REG_IDX_BITS-1:0] wr_index,
	input  logic [DENOM_BITS-1:0]   wr_data,
	// amount words
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [AMOUNT_BITS-1:0]  amount,
	// result words
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [IDX_BITS-1:0]     denom_index,
	output logic [AMOUNT_BITS-1:0]  coin_count,
	output logic                    is_last,
	output logic                    solved,
	output logic [AMOUNT_BITS-1:0]  leftover
);

	// configuration registers
	logic [COUNT_BITS-1:0]   denom_count_q;
	gcc_denoms_t             denoms_q;
	logic [REG_IDX_BITS-1:0] denom_sel;
	logic [COUNT_BITS-1:0]   count;

	gcc_cmd_t cmd;
	gcc_sts_t sts;

	assign denom_sel = wr_index - REG_DENOM_FIRST;
	assign count     = active_count(denom_count_q);

	// writes past the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			denom_count_q <= COUNT_BITS'(1);
			denoms_q      <= {MAX_DENOMS{DENOM_BITS'(1)}};
		end else if (wr_en) begin
			if (wr_index == REG_DENOM_COUNT) begin
				denom_count_q <= wr_data[COUNT_BITS-1:0];
			end else if (wr_index < REG_IDX_BITS'(NUM_REGS)) begin
				denoms_q[denom_sel] <= wr_data;
			end
		end
	end

	gcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.count    (count),
		.sts      (sts),
		.cmd      (cmd)
	);

	gcc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.denoms      (denoms_q),
		.amount      (amount),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.denom_index (denom_index),
		.coin_count  (coin_count),
		.is_last     (is_last),
		.solved      (solved),
		.leftover    (leftover)
	);

`ifndef SYNTHESIS
	// a pending non-final word means the walk is still running
	a_busy_mid_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_last) |-> !in_ready)
		else $error("amount taken while a walk is in progress");

	a_solved_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && solved) |-> (is_last && (leftover == '0)))
		else $error("solved flag with leftover amount");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second amount taken before the walk started");
`endif

endmodule
